// ===== rtl/hcrr_pkg.sv =====
// Package for the hashed counter random range generator: constants, types, fold function.
`default_nettype none
package hcrr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] STEP_INC = 32'hE120FC15;
  localparam logic [DATA_W-1:0] MUL_ONE  = 32'h4A39B70D;
  localparam logic [DATA_W-1:0] MUL_TWO  = 32'h12FAD5C9;

  // command codes carried on s_tuser
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  // configuration register indexes
  localparam logic CFG_RANGE_MIN = 1'b0;
  localparam logic CFG_RANGE_MAX = 1'b1;

  typedef enum logic {
    MUL_SEL_ONE,
    MUL_SEL_TWO
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_START,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // xor the high and low halves of a double-width product
  function automatic logic [DATA_W-1:0] fold(input logic [2*DATA_W-1:0] p);
    return p[2*DATA_W-1:DATA_W] ^ p[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hcrr_mul.sv =====
// Shared 32x32 multiplier with a registered 64-bit product and a constant operand select.
`default_nettype none
module hcrr_mul
  import hcrr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [DATA_W-1:0]   operand,
  input  wire mul_sel_t            sel,
  output logic      [2*DATA_W-1:0] product
);

  logic [DATA_W-1:0] coef;

  always_comb begin
    case (sel)
      MUL_SEL_ONE: coef = MUL_ONE;
      MUL_SEL_TWO: coef = MUL_TWO;
      default:     coef = MUL_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    product <= {{DATA_W{1'b0}}, operand} * {{DATA_W{1'b0}}, coef};
  end

endmodule
`default_nettype wire

// ===== rtl/hcrr_div.sv =====
// Iterative restoring divider: one remainder bit per cycle, remainder only.
`default_nettype none
module hcrr_div
  import hcrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic      [DATA_W-1:0] remainder,
  output div_status_t            status
);

  logic [DATA_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_diff;

  always_comb begin
    rem_sh   = {remainder, quo[DATA_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quo <= {quo[DATA_W-2:0], 1'b0};
      // subtract when the shifted remainder covers the divisor
      if (!rem_diff[DATA_W]) begin
        remainder <= rem_diff[DATA_W-1:0];
      end else begin
        remainder <= rem_sh[DATA_W-1:0];
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule
`default_nettype wire

// ===== rtl/hashed_counter_random_range.sv =====
// Top level: counter, sequencer, config registers and output register of the range generator.
//
//  channel  | direction | tdata                      | tuser
//  ---------+-----------+----------------------------+----------------------------------
//  s_*      | in        | [31:0] seed_value          | [0] command (0 draw, 1 seed)
//  m_*      | out       | [31:0] random_value        | [0] span_error
//  cfg_*    | in        | cfg_data[31:0], index 0 range_min, 1 range_max (write only)
//
//  A seed loads the counter and gives no result. A draw goes from acceptance to
//  the output register through two passes of the shared multiplier, a setup
//  state, 32 steps of the radix-2 remainder unit, a finish state and the output
//  load. A zero span skips the divider.
//  s_tready is high only when idle.
//  A finished result waiting on m_tready holds the sequencer in its last state.
//  rst is synchronous and clears the counter, config registers and valid.
`default_nettype none
module hashed_counter_random_range
  import hcrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] seed_value
  input  wire logic              s_tuser,   // [0] command
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [DATA_W-1:0] m_tdata,   // [31:0] random_value
  output logic                   m_tuser,   // [0] span_error
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data
);

  state_t              state;
  state_t              state_next;
  logic [DATA_W-1:0]   counter;
  logic [DATA_W-1:0]   range_min;
  logic [DATA_W-1:0]   range_max;
  logic [DATA_W-1:0]   span;
  logic                s_fire;
  logic                out_free;
  logic [DATA_W-1:0]   mul_operand;
  mul_sel_t            mul_sel;
  logic [2*DATA_W-1:0] product;
  logic                div_start;
  logic [DATA_W-1:0]   remainder;
  div_status_t         div_st;
  logic [DATA_W-1:0]   result;
  logic                result_err;
  logic                load_out;

  assign span     = range_max - range_min;
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  hcrr_mul u_mul (
    .clk     (clk),
    .operand (mul_operand),
    .sel     (mul_sel),
    .product (product)
  );

  hcrr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (fold(product)),
    .divisor   (span),
    .remainder (remainder),
    .status    (div_st)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire && s_tuser == CMD_DRAW) state_next = ST_MUL1;
      end
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_DIV_START;
      ST_DIV_START: state_next = (span == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (div_st.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready    = 1'b0;
    mul_operand = counter;
    mul_sel     = MUL_SEL_ONE;
    div_start   = 1'b0;
    load_out    = 1'b0;
    case (state)
      ST_IDLE:      s_tready = 1'b1;
      ST_MUL1: begin
        mul_operand = counter;
        mul_sel     = MUL_SEL_ONE;
      end
      ST_MUL2: begin
        mul_operand = fold(product);
        mul_sel     = MUL_SEL_TWO;
      end
      ST_DIV_START: div_start = (span != '0);
      ST_DIV:       ;
      ST_DONE:      load_out = out_free;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      counter   <= '0;
      range_min <= '0;
      range_max <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (s_fire) begin
        if (s_tuser == CMD_SEED) begin
          counter <= s_tdata;
        end else begin
          counter <= counter + STEP_INC;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_MIN: range_min <= cfg_data;
          CFG_RANGE_MAX: range_max <= cfg_data;
          default:       ;
        endcase
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hold the result until the output register is free
  always_ff @(posedge clk) begin
    if (state == ST_DIV_START && span == '0) begin
      result     <= range_min;
      result_err <= 1'b1;
    end else if (state == ST_DIV && div_st.done) begin
      result     <= remainder + range_min;
      result_err <= 1'b0;
    end
    if (load_out) begin
      m_tdata <= result;
      m_tuser <= result_err;
    end
  end

  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tuser == CMD_DRAW) |=> (state == ST_MUL1))
    else $error("draw did not start the multiply pass");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_st.busy || div_st.done))
    else $error("divide state without a running divider");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (m_tvalid && state == ST_IDLE))
    else $error("result not presented after load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> !s_tready)
    else $error("input accepted while the divider runs");

endmodule
`default_nettype wire
